[src/awex_pkg.sv]
// Shared types and constants for the agent wealth exchange engine.
// Holds the request structs, the op, rule, register and state codes.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package awex_pkg;

  localparam int NUM_AGENTS     = 1024;
  localparam int AGENT_BITS     = $clog2(NUM_AGENTS);
  localparam int COUNT_BITS     = AGENT_BITS + 1;
  localparam int WEALTH_BITS    = 32;
  localparam int FRACTION_BITS  = 16;
  localparam int TOTAL_BITS     = WEALTH_BITS + 1;
  localparam int POOL_BITS      = WEALTH_BITS + AGENT_BITS;
  localparam int MUL_B_BITS     = FRACTION_BITS + 1;
  localparam int PROD_BITS      = TOTAL_BITS + MUL_B_BITS;
  localparam int DIV_CNT_BITS   = $clog2(POOL_BITS + 1);
  localparam int INIT_BITS      = 22;
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 22;

  localparam logic [MUL_B_BITS-1:0]  FRAC_ONE   = {1'b1, {FRACTION_BITS{1'b0}}};
  localparam logic [WEALTH_BITS-1:0] WEALTH_MAX = {WEALTH_BITS{1'b1}};

  typedef enum logic [1:0] {
    OP_EXCHANGE = 2'd0,
    OP_TAX      = 2'd1,
    OP_FILL     = 2'd2,
    OP_READ     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    RULE_SPLIT  = 2'd0,
    RULE_SAVING = 2'd1,
    RULE_YARD   = 2'd2,
    RULE_NONE   = 2'd3
  } rule_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_RULE   = 3'd0,
    CFG_SAVING = 3'd1,
    CFG_STAKE  = 3'd2,
    CFG_TAX    = 3'd3,
    CFG_COUNT  = 3'd4,
    CFG_INIT   = 3'd5
  } cfg_index_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EX_LOAD,
    ST_EX_MA,
    ST_EX_MB,
    ST_EX_MC,
    ST_EX_SUM,
    ST_EX_WR1,
    ST_EX_WR2,
    ST_TX_P1,
    ST_TX_DIV,
    ST_TX_P2,
    ST_FILL,
    ST_RD_WAIT,
    ST_EMIT
  } state_t;

  typedef struct packed {
    op_t                      op;
    logic [AGENT_BITS-1:0]    first_agent;
    logic [AGENT_BITS-1:0]    second_agent;
    logic [FRACTION_BITS-1:0] random_fraction;
  } request_in_t;

  typedef struct packed {
    logic [WEALTH_BITS-1:0] first_wealth;
    logic [WEALTH_BITS-1:0] second_wealth;
    logic [WEALTH_BITS-1:0] share_paid;
    logic                   status;
  } request_out_t;

endpackage

[src/agent_wealth_exchange_engine_top.sv]
// Top level of the agent wealth exchange engine: wealth memory, sequencer,
// shared multiplier and output register. Depends on awex_pkg and awex_div.
//
// Usage:
//   in_request carries one op (exchange, tax, fill, read) under in_valid/in_stall;
//   out_request returns exactly one result per request under out_valid/out_stall.
//   Configuration registers are written through cfg_we/cfg_index/cfg_data; the
//   user must write them only while the block is idle (the block does not enforce
//   this); indexes past the last register are ignored.
//   One request is worked at a time; in_stall is high while it is in progress.
//   The block has a single memory write port and one shared 33x17 multiplier.
//   A fill writes all NUM_AGENTS entries; a tax request makes two passes over
//   the n agents in use around a serial divide, and a zero tax rate or a bad
//   index skips straight to the result.
//   A finished result sits in the output register; the next request is taken
//   while it waits, and a further result holds until the receiver takes it.
//   Reset (rst, synchronous) clears control and configuration, not the memory:
//   agent wealth is undefined until the first fill request.
`timescale 1ns / 1ps

module agent_wealth_exchange_engine_top (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  awex_pkg::request_in_t              in_request,
  output logic                               out_valid,
  input  logic                               out_stall,
  output awex_pkg::request_out_t             out_request,
  input  logic                               cfg_we,
  input  logic [awex_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [awex_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
  import awex_pkg::*;

  rule_t                    rule;
  logic [FRACTION_BITS-1:0] lam;
  logic [FRACTION_BITS-1:0] stake_f;
  logic [FRACTION_BITS-1:0] tau;
  logic [COUNT_BITS-1:0]    count_cfg;
  logic [INIT_BITS-1:0]     init_w;
  logic [COUNT_BITS-1:0]    eff_n;

  state_t state;
  state_t state_next;

  logic [WEALTH_BITS-1:0] mem [NUM_AGENTS];
  logic [AGENT_BITS-1:0]  rd_addr_a;
  logic [AGENT_BITS-1:0]  rd_addr_b;
  logic [WEALTH_BITS-1:0] rdata_a;
  logic [WEALTH_BITS-1:0] rdata_b;
  logic                   wr_en;
  logic [AGENT_BITS-1:0]  wr_addr;
  logic [WEALTH_BITS-1:0] wr_data;

  logic [TOTAL_BITS-1:0]  mul_a;
  logic [MUL_B_BITS-1:0]  mul_b;
  logic [PROD_BITS-1:0]   prod;
  logic [TOTAL_BITS-1:0]  prod_frac;
  logic [WEALTH_BITS-1:0] tax_t;

  logic [AGENT_BITS-1:0]    pair_a;
  logic [AGENT_BITS-1:0]    pair_b;
  logic [FRACTION_BITS-1:0] eps;
  logic [WEALTH_BITS-1:0]   w1;
  logic [WEALTH_BITS-1:0]   min_w;
  logic [TOTAL_BITS-1:0]    total;
  logic [TOTAL_BITS-1:0]    part;
  logic [TOTAL_BITS-1:0]    w1_raw;
  logic [TOTAL_BITS-1:0]    w2_raw;
  logic [WEALTH_BITS-1:0]   w1_sat;

  logic [COUNT_BITS-1:0]  scan_cnt;
  logic                   scan_end;
  logic                   v1;
  logic                   v2;
  logic [AGENT_BITS-1:0]  a1;
  logic [AGENT_BITS-1:0]  a2;
  logic [WEALTH_BITS-1:0] w_s2;
  logic [TOTAL_BITS-1:0]  sum_p2;
  logic [POOL_BITS-1:0]   tax_pool;
  logic [WEALTH_BITS-1:0] share;

  logic                   div_start;
  logic                   div_done;
  logic [POOL_BITS-1:0]   div_quo;

  logic         accept;
  logic         bad_pair;
  logic         bad_read;
  logic         bad_status;
  logic         out_free;
  request_out_t res;

  function automatic logic [WEALTH_BITS-1:0] sat_wealth(input logic [TOTAL_BITS-1:0] v);
    return v[TOTAL_BITS-1] ? WEALTH_MAX : v[WEALTH_BITS-1:0];
  endfunction

  awex_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (tax_pool),
    .divisor  (eff_n),
    .done     (div_done),
    .quotient (div_quo)
  );

  always_comb begin
    if (count_cfg < COUNT_BITS'(2)) begin
      eff_n = COUNT_BITS'(2);
    end else if (count_cfg > COUNT_BITS'(NUM_AGENTS)) begin
      eff_n = COUNT_BITS'(NUM_AGENTS);
    end else begin
      eff_n = count_cfg;
    end
  end

  assign in_stall   = (state != ST_IDLE);
  assign accept     = in_valid && !in_stall;
  assign bad_read   = {1'b0, in_request.first_agent} >= eff_n;
  assign bad_pair   = bad_read || ({1'b0, in_request.second_agent} >= eff_n) ||
                      (in_request.first_agent == in_request.second_agent);
  assign bad_status = ((in_request.op == OP_EXCHANGE) && bad_pair) ||
                      ((in_request.op == OP_READ) && bad_read);
  assign out_free   = !out_valid || !out_stall;
  assign scan_end   = (scan_cnt == eff_n);
  assign prod_frac  = prod[FRACTION_BITS +: TOTAL_BITS];
  assign tax_t      = prod[FRACTION_BITS +: WEALTH_BITS];
  assign sum_p2     = {1'b0, rdata_a} + {1'b0, share};
  assign w1_sat     = sat_wealth(w1_raw);
  assign rd_addr_a  = (state == ST_IDLE) ? in_request.first_agent : scan_cnt[AGENT_BITS-1:0];
  assign rd_addr_b  = in_request.second_agent;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    wr_en      = 1'b0;
    wr_addr    = scan_cnt[AGENT_BITS-1:0];
    wr_data    = WEALTH_BITS'(init_w);
    mul_a      = {1'b0, rdata_a};
    mul_b      = {1'b0, tau};
    div_start  = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          case (in_request.op)
            OP_EXCHANGE: state_next = bad_pair ? ST_EMIT : ST_EX_LOAD;
            OP_TAX:      state_next = (tau == '0) ? ST_EMIT : ST_TX_P1;
            OP_FILL:     state_next = ST_FILL;
            OP_READ:     state_next = bad_read ? ST_EMIT : ST_RD_WAIT;
            default:     state_next = ST_EMIT;
          endcase
        end
      end
      ST_EX_LOAD: begin
        state_next = (rule == RULE_NONE) ? ST_EMIT : ST_EX_MA;
      end
      ST_EX_MA: begin
        if (rule == RULE_YARD) begin
          mul_a = {1'b0, min_w};
          mul_b = {1'b0, stake_f};
        end else begin
          mul_a = total;
          mul_b = {1'b0, eps};
        end
        state_next = (rule == RULE_SAVING) ? ST_EX_MB : ST_EX_SUM;
      end
      ST_EX_MB: begin
        mul_a      = {1'b0, w1};
        mul_b      = {1'b0, lam};
        state_next = ST_EX_MC;
      end
      ST_EX_MC: begin
        mul_a      = part;
        mul_b      = FRAC_ONE - {1'b0, lam};
        state_next = ST_EX_SUM;
      end
      ST_EX_SUM: begin
        state_next = ST_EX_WR1;
      end
      ST_EX_WR1: begin
        wr_en      = 1'b1;
        wr_addr    = pair_a;
        wr_data    = w1_sat;
        state_next = ST_EX_WR2;
      end
      ST_EX_WR2: begin
        wr_en      = 1'b1;
        wr_addr    = pair_b;
        wr_data    = sat_wealth(w2_raw);
        state_next = ST_EMIT;
      end
      ST_TX_P1: begin
        if (v2) begin
          wr_en   = 1'b1;
          wr_addr = a2;
          wr_data = w_s2 - tax_t;
        end
        if (scan_end && !v1 && !v2) begin
          div_start  = 1'b1;
          state_next = ST_TX_DIV;
        end
      end
      ST_TX_DIV: begin
        if (div_done) begin
          state_next = ST_TX_P2;
        end
      end
      ST_TX_P2: begin
        if (v1) begin
          wr_en   = 1'b1;
          wr_addr = a1;
          wr_data = sat_wealth(sum_p2);
        end
        if (scan_end && !v1) begin
          state_next = ST_EMIT;
        end
      end
      ST_FILL: begin
        wr_en = 1'b1;
        if (scan_cnt == COUNT_BITS'(NUM_AGENTS - 1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_RD_WAIT: begin
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      rule      <= RULE_SPLIT;
      lam       <= '0;
      stake_f   <= '0;
      tau       <= '0;
      count_cfg <= COUNT_BITS'(NUM_AGENTS);
      init_w    <= INIT_BITS'(1 << FRACTION_BITS);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RULE:   rule      <= rule_t'(cfg_data[1:0]);
        CFG_SAVING: lam       <= cfg_data[FRACTION_BITS-1:0];
        CFG_STAKE:  stake_f   <= cfg_data[FRACTION_BITS-1:0];
        CFG_TAX:    tau       <= cfg_data[FRACTION_BITS-1:0];
        CFG_COUNT:  count_cfg <= cfg_data[COUNT_BITS-1:0];
        CFG_INIT:   init_w    <= cfg_data[INIT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Wealth memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_a <= mem[rd_addr_a];
    rdata_b <= mem[rd_addr_b];
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Control counters, pipeline valids and output handshake
  always_ff @(posedge clk) begin
    if (rst) begin
      scan_cnt  <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      tax_pool  <= '0;
      out_valid <= 1'b0;
    end else begin
      v2 <= (state == ST_TX_P1) && v1;
      v1 <= 1'b0;
      case (state)
        ST_IDLE: begin
          scan_cnt <= '0;
          if (accept && in_request.op == OP_TAX && tau != '0) begin
            tax_pool <= '0;
          end
        end
        ST_TX_P1, ST_TX_P2: begin
          if (!scan_end) begin
            scan_cnt <= scan_cnt + 1'b1;
            v1       <= 1'b1;
          end
          if (state == ST_TX_P1 && v2) begin
            tax_pool <= tax_pool + POOL_BITS'(tax_t);
          end
        end
        ST_TX_DIV: scan_cnt <= '0;
        ST_FILL:   scan_cnt <= scan_cnt + 1'b1;
        default: ;
      endcase
      if (state == ST_EMIT && out_free) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    a1   <= scan_cnt[AGENT_BITS-1:0];
    a2   <= a1;
    w_s2 <= rdata_a;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          pair_a <= in_request.first_agent;
          pair_b <= in_request.second_agent;
          eps    <= in_request.random_fraction;
          res    <= {{(3 * WEALTH_BITS){1'b0}}, bad_status};
        end
      end
      ST_EX_LOAD: begin
        w1    <= rdata_a;
        total <= {1'b0, rdata_a} + {1'b0, rdata_b};
        min_w <= (rdata_a < rdata_b) ? rdata_a : rdata_b;
        if (rule == RULE_NONE) begin
          res <= {rdata_a, rdata_b, res.share_paid, res.status};
        end
      end
      ST_EX_MB, ST_EX_MC: part <= prod_frac;
      ST_EX_SUM: begin
        case (rule)
          RULE_SPLIT:  w1_raw <= prod_frac;
          RULE_SAVING: w1_raw <= part + prod_frac;
          RULE_YARD: begin
            if (eps[FRACTION_BITS-1]) begin
              w1_raw <= {1'b0, w1} - prod_frac;
            end else begin
              w1_raw <= {1'b0, w1} + prod_frac;
            end
          end
          default: w1_raw <= {1'b0, w1};
        endcase
      end
      ST_EX_WR1: begin
        res.first_wealth <= w1_sat;
        w2_raw           <= total - {1'b0, w1_sat};
      end
      ST_EX_WR2: res.second_wealth <= sat_wealth(w2_raw);
      ST_TX_DIV: begin
        if (div_done) begin
          share <= div_quo[WEALTH_BITS-1:0];
        end
      end
      ST_TX_P2:   res.share_paid   <= share;
      ST_RD_WAIT: res.first_wealth <= rdata_a;
      ST_EMIT: begin
        if (out_free) begin
          out_request <= res;
        end
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_idle_no_write: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !wr_en)
    else $error("memory write while idle");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_done |-> (state == ST_TX_DIV))
    else $error("divider finished outside the divide step");

  a_pair_distinct: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EX_WR2) |-> (pair_a != pair_b))
    else $error("exchange writes one agent twice");

  a_result_from_emit: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> ($past(state) == ST_EMIT))
    else $error("result raised outside the emit step");
`endif

endmodule

[src/awex_div.sv]
// Bit-serial restoring divider for the tax pool over the agent count.
// One quotient bit per cycle; depends on awex_pkg for widths.
`timescale 1ns / 1ps

module awex_div (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [awex_pkg::POOL_BITS-1:0]  dividend,
  input  logic [awex_pkg::COUNT_BITS-1:0] divisor,
  output logic                           done,
  output logic [awex_pkg::POOL_BITS-1:0]  quotient
);
  import awex_pkg::*;

  logic                    run;
  logic [DIV_CNT_BITS-1:0] cnt;
  logic [POOL_BITS-1:0]    quo;
  logic [COUNT_BITS-1:0]   rem;
  logic [COUNT_BITS-1:0]   dvs;
  logic [COUNT_BITS:0]     trial;
  logic [COUNT_BITS:0]     diff;
  logic                    fits;

  assign trial    = {rem, quo[POOL_BITS-1]};
  assign diff     = trial - {1'b0, dvs};
  assign fits     = trial >= {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        run <= 1'b1;
        cnt <= '0;
      end else if (run) begin
        if (cnt == DIV_CNT_BITS'(POOL_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
        cnt <= cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (run) begin
      rem <= fits ? diff[COUNT_BITS-1:0] : trial[COUNT_BITS-1:0];
      quo <= {quo[POOL_BITS-2:0], fits};
    end
  end

endmodule

[test/awex_checker.sv]
// Checker for the agent wealth exchange engine: watches the request, result and
// register ports, predicts each result and compares it field by field.
// Depends on awex_pkg for the request structs and the op, rule and register codes.
`timescale 1ns / 1ps

module awex_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  awex_pkg::request_in_t               in_request,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  awex_pkg::request_out_t              out_request,
  input  logic                                cfg_we,
  input  logic [awex_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [awex_pkg::CFG_DATA_BITS-1:0]  cfg_data,
  output int                                  fail_count,
  output int                                  pending_count
);
  import awex_pkg::*;

  logic [WEALTH_BITS-1:0]   wealth_mirror [NUM_AGENTS];
  rule_t                    rule_q;
  logic [FRACTION_BITS-1:0] saving_q;
  logic [FRACTION_BITS-1:0] stake_q;
  logic [FRACTION_BITS-1:0] tax_q;
  logic [COUNT_BITS-1:0]    count_q;
  logic [INIT_BITS-1:0]     init_q;
  request_out_t             expected_results [$];
  int                       mismatches = 0;

  function automatic logic [63:0] frac_mul(input logic [63:0] a, input logic [63:0] b);
    return (a * b) >> FRACTION_BITS;
  endfunction

  function automatic logic [63:0] clamp_wealth(input logic [63:0] v);
    return (v > WEALTH_MAX) ? {32'd0, WEALTH_MAX} : v;
  endfunction

  function automatic request_out_t predict_result(input request_in_t req);
    request_out_t res;
    logic [63:0]  n;
    logic [63:0]  w1;
    logic [63:0]  w2;
    logic [63:0]  total;
    logic [63:0]  stake;
    logic [63:0]  pool;
    logic [63:0]  share;
    logic [63:0]  cut;
    int           i;
    res = '0;
    if (count_q < 2) n = 2;
    else if (count_q > NUM_AGENTS) n = NUM_AGENTS;
    else n = count_q;
    case (req.op)
      OP_EXCHANGE: begin
        if (req.first_agent >= n || req.second_agent >= n ||
            req.first_agent == req.second_agent) begin
          res.status = 1'b1;
        end else begin
          w1    = wealth_mirror[req.first_agent];
          w2    = wealth_mirror[req.second_agent];
          total = w1 + w2;
          if (rule_q != RULE_NONE) begin
            case (rule_q)
              RULE_SPLIT: w1 = frac_mul(total, req.random_fraction);
              RULE_SAVING: begin
                w1 = frac_mul(w1, saving_q) +
                     frac_mul(frac_mul(total, req.random_fraction), FRAC_ONE - saving_q);
              end
              default: begin
                stake = frac_mul((w1 < w2) ? w1 : w2, stake_q);
                if (!req.random_fraction[FRACTION_BITS-1]) w1 = w1 + stake;
                else w1 = w1 - stake;
              end
            endcase
            w1 = clamp_wealth(w1);
            w2 = clamp_wealth(total - w1);
            wealth_mirror[req.first_agent]  = w1[WEALTH_BITS-1:0];
            wealth_mirror[req.second_agent] = w2[WEALTH_BITS-1:0];
          end
          res.first_wealth  = w1[WEALTH_BITS-1:0];
          res.second_wealth = w2[WEALTH_BITS-1:0];
        end
      end
      OP_TAX: begin
        if (tax_q != 0) begin
          pool = 0;
          for (i = 0; i < n; i++) begin
            cut = frac_mul(wealth_mirror[i], tax_q);
            wealth_mirror[i] = wealth_mirror[i] - cut[WEALTH_BITS-1:0];
            pool = pool + cut;
          end
          share = pool / n;
          for (i = 0; i < n; i++) begin
            cut = clamp_wealth({32'd0, wealth_mirror[i]} + share);
            wealth_mirror[i] = cut[WEALTH_BITS-1:0];
          end
          res.share_paid = share[WEALTH_BITS-1:0];
        end
      end
      OP_FILL: begin
        for (i = 0; i < NUM_AGENTS; i++) wealth_mirror[i] = WEALTH_BITS'(init_q);
      end
      default: begin
        if (req.first_agent >= n) res.status = 1'b1;
        else res.first_wealth = wealth_mirror[req.first_agent];
      end
    endcase
    return res;
  endfunction

  task automatic check_result(input request_out_t got);
    request_out_t want;
    if (expected_results.size() == 0) begin
      $error("result with no request outstanding: %h", got);
      mismatches++;
    end else begin
      want = expected_results.pop_front();
      if (got.first_wealth !== want.first_wealth) begin
        $error("first_wealth mismatch: expected %0h, got %0h",
               want.first_wealth, got.first_wealth);
        mismatches++;
      end
      if (got.second_wealth !== want.second_wealth) begin
        $error("second_wealth mismatch: expected %0h, got %0h",
               want.second_wealth, got.second_wealth);
        mismatches++;
      end
      if (got.share_paid !== want.share_paid) begin
        $error("share_paid mismatch: expected %0h, got %0h",
               want.share_paid, got.share_paid);
        mismatches++;
      end
      if (got.status !== want.status) begin
        $error("status mismatch: expected %0h, got %0h", want.status, got.status);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rule_q   = RULE_SPLIT;
      saving_q = '0;
      stake_q  = '0;
      tax_q    = '0;
      count_q  = COUNT_BITS'(NUM_AGENTS);
      init_q   = 22'd65536;
      expected_results.delete();
    end else begin
      if (out_valid && !out_stall) check_result(out_request);
      if (cfg_we) begin
        case (cfg_index)
          CFG_RULE:   rule_q   = rule_t'(cfg_data[1:0]);
          CFG_SAVING: saving_q = cfg_data[FRACTION_BITS-1:0];
          CFG_STAKE:  stake_q  = cfg_data[FRACTION_BITS-1:0];
          CFG_TAX:    tax_q    = cfg_data[FRACTION_BITS-1:0];
          CFG_COUNT:  count_q  = cfg_data[COUNT_BITS-1:0];
          CFG_INIT:   init_q   = cfg_data[INIT_BITS-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) expected_results.push_back(predict_result(in_request));
    end
    fail_count    <= mismatches;
    pending_count <= expected_results.size();
  end

endmodule

[test/tb_top.sv]
// Top of the agent wealth exchange engine testbench: clock, reset, register
// writes, directed and random requests, receiver stalls and the verdict.
// Depends on awex_pkg, awex_checker and agent_wealth_exchange_engine_top.
`timescale 1ns / 1ps

module tb_top;
  import awex_pkg::*;

  logic                      clk = 1'b0;
  logic                      rst;
  logic                      in_valid;
  logic                      in_stall;
  request_in_t               in_request;
  logic                      out_valid;
  logic                      out_stall;
  request_out_t              out_request;
  logic                      cfg_we;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  int                        fail_count;
  int                        pending_count;
  bit                        no_idle = 1'b0;
  bit                        long_hold = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  agent_wealth_exchange_engine_top u_dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_request (in_request),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_request(out_request),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  awex_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_request   (in_request),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_request  (out_request),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .pending_count(pending_count)
  );

  task automatic send_request(input op_t code, input logic [AGENT_BITS-1:0] a,
                              input logic [AGENT_BITS-1:0] b,
                              input logic [FRACTION_BITS-1:0] eps);
    request_in_t req;
    int          gap;
    req.op              = code;
    req.first_agent     = a;
    req.second_agent    = b;
    req.random_fraction = eps;
    gap = no_idle ? 0 : int'($urandom_range(0, 6));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_request <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic put_reg(input cfg_index_t idx, input logic [CFG_DATA_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
  endtask

  task automatic write_config(input rule_t rule, input logic [FRACTION_BITS-1:0] lam,
                              input logic [FRACTION_BITS-1:0] stake,
                              input logic [FRACTION_BITS-1:0] tau,
                              input logic [COUNT_BITS-1:0] count,
                              input logic [INIT_BITS-1:0] init);
    wait_idle();
    put_reg(CFG_RULE, rule);
    put_reg(CFG_SAVING, lam);
    put_reg(CFG_STAKE, stake);
    put_reg(CFG_TAX, tau);
    put_reg(CFG_COUNT, count);
    put_reg(CFG_INIT, init);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [FRACTION_BITS-1:0] pick_frac();
    case ($urandom_range(0, 3))
      0: return '0;
      1: return '1;
      default: return FRACTION_BITS'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [COUNT_BITS-1:0] pick_count();
    case ($urandom_range(0, 9))
      0: return 11'd0;
      1: return 11'd1;
      2: return 11'd2;
      3: return 11'd1024;
      4: return 11'd2047;
      5: return COUNT_BITS'($urandom_range(0, 2047));
      default: return COUNT_BITS'($urandom_range(2, 40));
    endcase
  endfunction

  function automatic logic [INIT_BITS-1:0] pick_init();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      default: return INIT_BITS'($urandom_range(0, 4194303));
    endcase
  endfunction

  initial begin : receiver
    int hold;
    out_stall <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        hold = 400;
      end else begin
        hold = no_idle ? 0 : int'($urandom_range(0, 6));
      end
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  initial begin
    #200_000_000;
    $display("Some tests failed");
    $finish;
  end

  initial begin : stimulus
    logic [COUNT_BITS-1:0]    count;
    logic [AGENT_BITS-1:0]    a;
    logic [AGENT_BITS-1:0]    b;
    logic [FRACTION_BITS-1:0] eps;
    rule_t                    rule;
    op_t                      code;
    int                       n;
    int                       sel;
    int                       phase;
    int                       k;

    rst        <= 1'b1;
    in_valid   <= 1'b0;
    in_request <= '0;
    cfg_we     <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset settings: split rule, all agents, zero tax rate
    send_request(OP_FILL, 10'd0, 10'd0, 16'h0000);
    send_request(OP_READ, 10'd0, 10'd0, 16'h0000);
    send_request(OP_READ, 10'd1023, 10'd0, 16'h0000);
    send_request(OP_EXCHANGE, 10'd0, 10'd1023, 16'h0000);
    send_request(OP_EXCHANGE, 10'd1023, 10'd0, 16'hFFFF);
    send_request(OP_EXCHANGE, 10'd5, 10'd5, 16'h1234);
    send_request(OP_TAX, 10'd0, 10'd0, 16'h0000);
    send_request(OP_READ, 10'd1023, 10'd0, 16'h0000);

    write_config(RULE_YARD, 16'h0000, 16'hFFFF, 16'hFFFF, 11'd2, 22'h3FFFFF);
    send_request(OP_FILL, 10'h3FF, 10'h3FF, 16'hFFFF);
    send_request(OP_EXCHANGE, 10'd0, 10'd1, 16'h0000);
    send_request(OP_EXCHANGE, 10'd1, 10'd0, 16'h8000);
    send_request(OP_EXCHANGE, 10'd0, 10'd2, 16'h4000);
    send_request(OP_EXCHANGE, 10'd1023, 10'd1, 16'hC000);
    send_request(OP_READ, 10'd2, 10'd0, 16'h0000);
    send_request(OP_READ, 10'd1, 10'd0, 16'h0000);
    send_request(OP_TAX, 10'd0, 10'd0, 16'h0000);
    send_request(OP_READ, 10'd0, 10'd0, 16'h0000);

    write_config(RULE_SAVING, 16'hFFFF, 16'h0000, 16'h0001, 11'd0, 22'd0);
    send_request(OP_EXCHANGE, 10'd0, 10'd1, 16'h8000);
    send_request(OP_FILL, 10'd0, 10'd0, 16'h0000);
    send_request(OP_EXCHANGE, 10'd1, 10'd0, 16'hFFFF);
    send_request(OP_TAX, 10'd0, 10'd0, 16'h0000);

    write_config(RULE_SAVING, 16'h0000, 16'h8000, 16'h8000, 11'd2047, 22'd65536);
    send_request(OP_FILL, 10'd0, 10'd0, 16'h0000);
    send_request(OP_EXCHANGE, 10'd10, 10'd900, 16'h7FFF);

    write_config(RULE_NONE, 16'h0000, 16'h8000, 16'h8000, 11'd1024, 22'd65536);
    send_request(OP_EXCHANGE, 10'd3, 10'd700, 16'hABCD);
    send_request(OP_READ, 10'd3, 10'd0, 16'h0000);

    for (phase = 0; phase < 10; phase++) begin
      rule  = ($urandom_range(0, 9) == 9) ? RULE_NONE : rule_t'($urandom_range(0, 2));
      count = pick_count();
      n = (count < 2) ? 2 : (count > NUM_AGENTS) ? NUM_AGENTS : count;
      write_config(rule, pick_frac(), pick_frac(), pick_frac(), count, pick_init());
      send_request(OP_FILL, AGENT_BITS'($urandom_range(0, 1023)),
                   AGENT_BITS'($urandom_range(0, 1023)),
                   FRACTION_BITS'($urandom_range(0, 65535)));
      // hold off the receiver so the block backs up into its input
      if (phase == 2) long_hold = 1'b1;
      for (k = 0; k < 188; k++) begin
        if ($urandom_range(0, 49) == 0) no_idle = !no_idle;
        eps = FRACTION_BITS'($urandom_range(0, 65535));
        a = AGENT_BITS'($urandom_range(0, n - 1));
        b = AGENT_BITS'($urandom_range(0, n - 1));
        if (b == a) b = AGENT_BITS'((a + 1) % n);
        sel = $urandom_range(0, 99);
        if (sel < 6) a = AGENT_BITS'($urandom_range(0, 1023));
        else if (sel < 9) b = AGENT_BITS'($urandom_range(0, 1023));
        else if (sel < 11) b = a;
        sel = $urandom_range(0, 99);
        if (sel < 2) code = OP_FILL;
        else if (sel < ((n <= 64) ? 6 : 3)) code = OP_TAX;
        else if (sel < 25) code = OP_READ;
        else code = OP_EXCHANGE;
        send_request(code, a, b, eps);
      end
    end

    no_idle = 1'b0;
    wait_idle();
    repeat (50) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[sim.f]
src/awex_pkg.sv
src/awex_div.sv
src/agent_wealth_exchange_engine_top.sv
test/awex_checker.sv
test/tb_top.sv
